// ===== hdl/lph_pkg.sv =====
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package lph_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SLOTS_W = 5;

  localparam logic [SLOTS_W-1:0] SLOTS_RESET     = 5'd10;
  localparam logic [VAL_W-1:0]   NOT_FOUND_VALUE = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } lph_op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } lph_status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_LIVE    = 2'd1,
    MARK_DELETED = 2'd2
  } lph_mark_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MOD   = 2'd1,
    ST_PROBE = 2'd2,
    ST_CLEAR = 2'd3
  } lph_state_e;

  typedef struct packed {
    lph_op_e                  opcode;
    logic [KEY_W-1:0]         key;
    logic signed [VAL_W-1:0]  value;
  } lph_in_t;

  typedef struct packed {
    logic                     found;
    logic signed [VAL_W-1:0]  read_value;
    lph_status_e              status;
    logic                     table_empty;
  } lph_out_t;

endpackage

// ===== hdl/lph_mod.sv =====
// Bit-serial restoring remainder unit: key modulo the active slot count.
// One dividend bit per cycle. Depends on lph_pkg.
`timescale 1ns / 1ps
module lph_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lph_pkg::KEY_W-1:0]   dividend_i,
  input  logic [lph_pkg::SLOTS_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [lph_pkg::SLOTS_W-1:0] rem_o
);
  import lph_pkg::*;

  localparam logic [SLOTS_W-1:0] LAST_STEP = SLOTS_W'(KEY_W - 1);

  logic               busy_q;
  logic               done_q;
  logic [SLOTS_W-1:0] cnt_q;
  logic [KEY_W-1:0]   dvd_q;
  logic [SLOTS_W-1:0] div_q;
  logic [SLOTS_W-1:0] rem_q;
  logic [SLOTS_W:0]   trial;
  logic [SLOTS_W:0]   diff;
  logic [SLOTS_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[KEY_W-1]};
    diff  = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      rem_d = diff[SLOTS_W-1:0];
    end else begin
      rem_d = trial[SLOTS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table: sequencer, slot marks and slot memory.
// Depends on lph_pkg and lph_mod.
//
//   channel   handshake                      payload
//   in        start_i / busy_o               in_i  (opcode, key, value)
//   result    done_o (one-cycle strobe)      res_o (found, read_value, status, table_empty)
//   config    cfg_valid_i / cfg_ready_o      cfg_data_i (slots_in_use)
//
// Insert, remove and search pass through ST_MOD, where the serial modulo unit forms the
// home slot, and then ST_PROBE, which probes at least one slot and at most the active
// slot count. Clear passes through ST_CLEAR alone.
// Each probe step reads one slot of the memory per cycle.
// Reset and every config write empty all slots at once; slots_in_use resets to 10.
// Results are not stalled: done_o is high for one cycle and start_i may be taken then.
`timescale 1ns / 1ps
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  lph_pkg::lph_in_t            in_i,
  output logic                        done_o,
  output lph_pkg::lph_out_t           res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lph_pkg::SLOTS_W-1:0] cfg_data_i
);
  import lph_pkg::*;

  localparam int unsigned SLOT_MAX   = (1 << SLOTS_W) - 1;
  localparam int unsigned MARK_DEPTH = (TABLE_DEPTH < SLOT_MAX) ? TABLE_DEPTH : SLOT_MAX;
  localparam int unsigned IDX_W      = $clog2(MARK_DEPTH);
  localparam int unsigned LIVE_W     = $clog2(MARK_DEPTH + 1);
  localparam logic [SLOTS_W-1:0] N_MAX = SLOTS_W'(MARK_DEPTH);

  lph_state_e         state_q, state_d;
  logic [SLOTS_W-1:0] slots_q;
  lph_mark_e          mark_q [MARK_DEPTH];
  logic [LIVE_W-1:0]  live_q, live_d;
  lph_op_e            op_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [IDX_W-1:0]   h_q, h_d;
  logic [SLOTS_W-1:0] step_q, step_d;
  logic               free_vld_q, free_vld_d;
  logic [IDX_W-1:0]   free_q, free_d;
  logic               done_q;
  lph_out_t           res_q, res_d;

  logic [KEY_W-1:0]   key_mem  [MARK_DEPTH];
  logic [VAL_W-1:0]   data_mem [MARK_DEPTH];
  logic [KEY_W-1:0]   key_rd_q;
  logic [VAL_W-1:0]   data_rd_q;

  logic               accept;
  logic               cfg_wr;
  logic [SLOTS_W-1:0] n_act;
  logic               mod_start;
  logic               mod_done;
  logic [SLOTS_W-1:0] mod_rem;
  lph_mark_e          cur_mark;
  logic               key_hit;
  logic               is_free;
  logic               last_step;
  logic [IDX_W:0]     h_inc;
  logic [IDX_W-1:0]   h_wrap;
  logic               free_sel_vld;
  logic [IDX_W-1:0]   free_sel;
  logic               finish;
  logic               hit;
  logic               mem_wr;
  logic               key_wr;
  logic [IDX_W-1:0]   wr_idx;
  logic               mark_wr;
  logic [IDX_W-1:0]   mark_idx;
  lph_mark_e          mark_val;
  logic               clr_all;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;

  always_comb begin
    if (slots_q == '0) begin
      n_act = SLOTS_W'(1);
    end else if (slots_q > N_MAX) begin
      n_act = N_MAX;
    end else begin
      n_act = slots_q;
    end
  end

  lph_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_i.key),
    .divisor_i  (n_act),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign cur_mark     = mark_q[h_q];
  assign key_hit      = (cur_mark == MARK_LIVE) && (key_rd_q == key_q);
  assign is_free      = (cur_mark == MARK_EMPTY) || (cur_mark == MARK_DELETED);
  assign last_step    = ((step_q + 1'b1) == n_act);
  assign h_inc        = {1'b0, h_q} + 1'b1;
  assign h_wrap       = ((SLOTS_W + 1)'(h_inc) >= (SLOTS_W + 1)'(n_act)) ? '0
                                                                          : h_inc[IDX_W-1:0];
  assign free_sel_vld = free_vld_q || is_free;
  assign free_sel     = free_vld_q ? free_q : h_q;

  always_comb begin
    state_d    = state_q;
    h_d        = h_q;
    step_d     = step_q;
    free_vld_d = free_vld_q;
    free_d     = free_q;
    mod_start  = 1'b0;
    finish     = 1'b0;
    hit        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (in_i.opcode == OP_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            mod_start = 1'b1;
            state_d   = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          h_d        = mod_rem[IDX_W-1:0];
          step_d     = '0;
          free_vld_d = 1'b0;
          state_d    = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (is_free && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_d     = h_q;
        end
        if (key_hit) begin
          hit    = 1'b1;
          finish = 1'b1;
        end else if (cur_mark == MARK_EMPTY || last_step) begin
          finish = 1'b1;
        end else begin
          h_d    = h_wrap;
          step_d = step_q + 1'b1;
        end
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        finish  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_d.found      = 1'b0;
    res_d.read_value = NOT_FOUND_VALUE;
    res_d.status     = STAT_OK;
    live_d           = live_q;
    mem_wr           = 1'b0;
    key_wr           = 1'b0;
    wr_idx           = h_q;
    mark_wr          = 1'b0;
    mark_idx         = h_q;
    mark_val         = MARK_LIVE;
    clr_all          = 1'b0;
    if (finish) begin
      unique case (op_q)
        OP_INSERT: begin
          if (hit) begin
            mem_wr = 1'b1;
          end else if (free_sel_vld) begin
            mem_wr   = 1'b1;
            key_wr   = 1'b1;
            wr_idx   = free_sel;
            mark_wr  = 1'b1;
            mark_idx = free_sel;
            live_d   = live_q + 1'b1;
          end else begin
            res_d.status = STAT_FULL;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            mark_wr     = 1'b1;
            mark_val    = MARK_DELETED;
            res_d.found = 1'b1;
            if (live_q != '0) begin
              live_d = live_q - 1'b1;
            end
          end else begin
            res_d.status = STAT_NOT_FOUND;
          end
        end
        OP_SEARCH: begin
          if (hit) begin
            res_d.found      = 1'b1;
            res_d.read_value = data_rd_q;
          end else begin
            res_d.status = STAT_NOT_FOUND;
          end
        end
        OP_CLEAR: begin
          clr_all = 1'b1;
          live_d  = '0;
        end
        default: begin
          clr_all = 1'b0;
        end
      endcase
    end
    res_d.table_empty = (live_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slots_q    <= SLOTS_RESET;
      live_q     <= '0;
      done_q     <= 1'b0;
      step_q     <= '0;
      free_vld_q <= 1'b0;
      for (int i = 0; i < MARK_DEPTH; i++) begin
        mark_q[i] <= MARK_EMPTY;
      end
    end else begin
      state_q    <= state_d;
      done_q     <= finish;
      step_q     <= step_d;
      free_vld_q <= free_vld_d;
      if (cfg_wr) begin
        slots_q <= cfg_data_i;
      end
      if (cfg_wr || clr_all) begin
        live_q <= '0;
        for (int i = 0; i < MARK_DEPTH; i++) begin
          mark_q[i] <= MARK_EMPTY;
        end
      end else begin
        live_q <= live_d;
        if (mark_wr) begin
          mark_q[mark_idx] <= mark_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    free_q <= free_d;
    if (accept) begin
      op_q  <= in_i.opcode;
      key_q <= in_i.key;
      val_q <= in_i.value;
    end
    if (finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      data_mem[wr_idx] <= val_q;
    end
    if (key_wr) begin
      key_mem[wr_idx] <= key_q;
    end
    key_rd_q  <= key_mem[h_d];
    data_rd_q <= data_mem[h_d];
  end

endmodule

// ===== hdl/lph_checker.sv =====
// Port-level checks on the hash table's command and result timing and on failed results' fields.
// Depends on lph_pkg; bound to linear_probe_hash_table below.
`timescale 1ns / 1ps
module lph_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input lph_pkg::lph_out_t res_o
);
  import lph_pkg::*;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_done_ends_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && $past(busy_o)))
    else $error("result word not at the end of a busy period");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result words in a row");

  a_miss_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != STAT_OK) |->
      (!res_o.found && res_o.read_value == NOT_FOUND_VALUE))
    else $error("failed operation reports a hit or a value");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);

// ===== sim/tb_linear_probe_hash_table.sv =====
// Self-checking testbench for linear_probe_hash_table: directed table, then random ops.
// Depends on lph_pkg and the block's RTL; predicts untyped results in-bench, typed rows give theirs.
`timescale 1ns / 1ps
module tb_linear_probe_hash_table;
  import lph_pkg::*;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned PHASE_OPS = 50;

  typedef enum {ROW_CFG, ROW_OP} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    lph_in_t            word;
    bit                 typed;
    lph_out_t           want;
    logic [SLOTS_W-1:0] slots;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  lph_in_t             in_i;
  logic                done_o;
  lph_out_t            res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SLOTS_W-1:0]  cfg_data_i;

  logic [KEY_W-1:0]    tbl_key [DEPTH];
  logic [VAL_W-1:0]    tbl_val [DEPTH];
  lph_mark_e           tbl_mark [DEPTH];
  int unsigned         tbl_live;
  logic [SLOTS_W-1:0]  slots_reg;

  lph_out_t            op_results_q [$];
  row_t                directed_rows [$];
  int unsigned         mismatch_count = 0;

  linear_probe_hash_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb_linear_probe_hash_table: FAIL");
    $finish;
  end

  function automatic void empty_table();
    for (int i = 0; i < DEPTH; i++) tbl_mark[i] = MARK_EMPTY;
    tbl_live = 0;
  endfunction

  function automatic int unsigned active_span();
    int unsigned n;
    n = slots_reg;
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // Walk the chain; return the live match or -1, with the first reusable slot seen.
  function automatic int walk_chain(logic [KEY_W-1:0] k, output int free_idx);
    int unsigned n;
    int unsigned h;
    n = active_span();
    h = k % n;
    free_idx = -1;
    for (int unsigned s = 0; s < n; s++) begin
      if (tbl_mark[h] == MARK_EMPTY) begin
        if (free_idx < 0) free_idx = h;
        return -1;
      end
      if (tbl_mark[h] == MARK_DELETED) begin
        if (free_idx < 0) free_idx = h;
      end else if (tbl_key[h] == k) begin
        return h;
      end
      h = (h + 1 >= n) ? 0 : h + 1;
    end
    return -1;
  endfunction

  function automatic lph_out_t predict_table_op(lph_in_t w);
    lph_out_t r;
    int       hit;
    int       free_idx;
    r.found      = 1'b0;
    r.read_value = NOT_FOUND_VALUE;
    r.status     = STAT_OK;
    case (w.opcode)
      OP_INSERT: begin
        hit = walk_chain(w.key, free_idx);
        if (hit >= 0) begin
          tbl_val[hit] = w.value;
        end else if (free_idx >= 0) begin
          tbl_key[free_idx]  = w.key;
          tbl_val[free_idx]  = w.value;
          tbl_mark[free_idx] = MARK_LIVE;
          tbl_live++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        hit = walk_chain(w.key, free_idx);
        if (hit >= 0) begin
          tbl_mark[hit] = MARK_DELETED;
          if (tbl_live > 0) tbl_live--;
          r.found = 1'b1;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      OP_SEARCH: begin
        hit = walk_chain(w.key, free_idx);
        if (hit >= 0) begin
          r.read_value = tbl_val[hit];
          r.found      = 1'b1;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      default: empty_table();
    endcase
    r.table_empty = (tbl_live == 0);
    return r;
  endfunction

  function automatic void add_typed(lph_op_e op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                    bit typed, lph_out_t want);
    row_t row;
    row.kind        = ROW_OP;
    row.word.opcode = op;
    row.word.key    = k;
    row.word.value  = v;
    row.typed       = typed;
    row.want        = want;
    row.slots       = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_op(lph_op_e op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    add_typed(op, k, v, 1'b0, '0);
  endfunction

  function automatic void add_cfg(logic [SLOTS_W-1:0] n);
    row_t row;
    row.kind  = ROW_CFG;
    row.word  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.slots = n;
    directed_rows.push_back(row);
  endfunction

  task automatic issue_op(lph_in_t w, int unsigned gap, bit typed, lph_out_t want);
    lph_out_t model_out;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    model_out = predict_table_op(w);
    op_results_q.push_back(typed ? want : model_out);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (op_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slots(logic [SLOTS_W-1:0] n);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    slots_reg = n;
    empty_table();
  endtask

  function automatic lph_in_t random_word();
    lph_in_t     w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      w.opcode = OP_INSERT;
    else if (r < 70) w.opcode = OP_SEARCH;
    else if (r < 96) w.opcode = OP_REMOVE;
    else             w.opcode = OP_CLEAR;
    r = $urandom_range(0, 9);
    if (r < 6)      w.key = KEY_W'($urandom_range(0, 47));
    else if (r < 8) w.key = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 31));
    else            w.key = KEY_W'($urandom);
    r = $urandom_range(0, 9);
    case (r)
      0:       w.value = 32'h7FFF_FFFF;
      1:       w.value = 32'h8000_0000;
      2:       w.value = '1;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  always @(posedge clk_i) begin
    lph_out_t want;
    if (rst_ni && done_o) begin
      if (op_results_q.size() == 0) begin
        $display("%0t unexpected result: got found=%0b value=%h status=%0d empty=%0b",
                 $realtime, res_o.found, res_o.read_value, res_o.status, res_o.table_empty);
        mismatch_count++;
      end else begin
        want = op_results_q.pop_front();
        if (res_o.found !== want.found || res_o.read_value !== want.read_value ||
            res_o.status !== want.status || res_o.table_empty !== want.table_empty) begin
          $display("%0t mismatch: exp found=%0b value=%h status=%0d empty=%0b",
                   $realtime, want.found, want.read_value, want.status, want.table_empty);
          $display("%0t           got found=%0b value=%h status=%0d empty=%0b",
                   $realtime, res_o.found, res_o.read_value, res_o.status, res_o.table_empty);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [SLOTS_W-1:0] phase_slots [9];
    bit                 no_gap;
    int unsigned        gap;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    in_i        <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    slots_reg   = SLOTS_RESET;
    empty_table();

    add_typed(OP_SEARCH, 31'd0, 32'd0, 1'b1, '{1'b0, NOT_FOUND_VALUE, STAT_NOT_FOUND, 1'b1});
    add_typed(OP_REMOVE, 31'h7FFF_FFFF, 32'd0, 1'b1,
              '{1'b0, NOT_FOUND_VALUE, STAT_NOT_FOUND, 1'b1});
    add_typed(OP_CLEAR, 31'd0, 32'hFFFF_FFFF, 1'b1, '{1'b0, NOT_FOUND_VALUE, STAT_OK, 1'b1});
    add_typed(OP_INSERT, 31'd0, 32'h7FFF_FFFF, 1'b1, '{1'b0, NOT_FOUND_VALUE, STAT_OK, 1'b0});
    add_typed(OP_SEARCH, 31'd0, 32'd0, 1'b1, '{1'b1, 32'h7FFF_FFFF, STAT_OK, 1'b0});
    add_op(OP_INSERT, 31'd10, 32'h8000_0000);
    add_op(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_op(OP_SEARCH, 31'd10, 32'd0);
    add_op(OP_REMOVE, 31'd0, 32'd0);
    add_op(OP_SEARCH, 31'd10, 32'd0);
    add_op(OP_INSERT, 31'd20, 32'd123);
    add_op(OP_INSERT, 31'd10, 32'd55);
    add_op(OP_SEARCH, 31'd10, 32'd0);
    add_typed(OP_CLEAR, 31'd0, 32'd0, 1'b1, '{1'b0, NOT_FOUND_VALUE, STAT_OK, 1'b1});
    add_cfg(5'd1);
    add_typed(OP_INSERT, 31'd5, 32'd1, 1'b1, '{1'b0, NOT_FOUND_VALUE, STAT_OK, 1'b0});
    add_typed(OP_INSERT, 31'd6, 32'd2, 1'b1, '{1'b0, NOT_FOUND_VALUE, STAT_FULL, 1'b0});
    add_typed(OP_SEARCH, 31'd6, 32'd0, 1'b1, '{1'b0, NOT_FOUND_VALUE, STAT_NOT_FOUND, 1'b0});
    add_typed(OP_REMOVE, 31'd5, 32'd0, 1'b1, '{1'b1, NOT_FOUND_VALUE, STAT_OK, 1'b1});
    add_cfg(5'd0);
    add_op(OP_INSERT, 31'd9, 32'd3);
    add_op(OP_INSERT, 31'd9, 32'd4);
    add_op(OP_SEARCH, 31'd9, 32'd0);
    add_cfg(5'd31);
    add_op(OP_INSERT, 31'd15, 32'h5555_5555);
    add_op(OP_INSERT, 31'd31, 32'hAAAA_AAAA);
    add_op(OP_SEARCH, 31'd31, 32'd0);
    add_op(OP_REMOVE, 31'd31, 32'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_slots(directed_rows[i].slots);
      end else begin
        issue_op(directed_rows[i].word, $urandom_range(0, 7), directed_rows[i].typed,
                 directed_rows[i].want);
      end
    end

    phase_slots = '{5'd16, 5'd3, 5'd10, 5'd1, 5'd7, 5'd0, 5'd31, 5'd2, 5'd0};
    phase_slots[8] = SLOTS_W'($urandom_range(0, 31));
    foreach (phase_slots[p]) begin
      write_slots(phase_slots[p]);
      no_gap = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_OPS; n++) begin
        if (n == PHASE_OPS / 2) wait_drained();
        gap = no_gap ? 0 : $urandom_range(0, 7);
        issue_op(random_word(), gap, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_linear_probe_hash_table: PASS");
    end else begin
      $display("tb_linear_probe_hash_table: FAIL");
    end
    $finish;
  end

endmodule
